// ===== rtl/core/qse_pkg.sv =====
package qse_pkg;

  localparam int QSE_MAX_ITEMS = 64;
  localparam int VALUE_W = 32;
  localparam int BOUND_W = 6;
  localparam int STACK_DEPTH = 64;
  localparam int STK_AW = $clog2(STACK_DEPTH);
  localparam int SP_W = $clog2(STACK_DEPTH + 1);

  typedef struct packed {
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
  } stack_entry_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

// ===== rtl/core/qse_cmp.sv =====
module qse_cmp
  import qse_pkg::*;
(
  input  logic signed [VALUE_W-1:0] op_a,
  input  logic signed [VALUE_W-1:0] op_b,
  output cmp_res_t                  res
);

  assign res.lt = (op_a < op_b);
  assign res.eq = (op_a == op_b);

endmodule

// ===== rtl/core/qse_store.sv =====
module qse_store
  import qse_pkg::*;
#(
  parameter int DEPTH = QSE_MAX_ITEMS,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic [AW-1:0]             rd_addr_a,
  input  logic [AW-1:0]             rd_addr_b,
  output logic signed [VALUE_W-1:0] rd_data_a,
  output logic signed [VALUE_W-1:0] rd_data_b,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic signed [VALUE_W-1:0] wr_data
);

  logic signed [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ===== rtl/core/qse_stack.sv =====
module qse_stack
  import qse_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [STK_AW-1:0] wr_addr,
  input  stack_entry_t      wr_data,
  input  logic [STK_AW-1:0] rd_addr,
  output stack_entry_t      rd_data
);

  stack_entry_t mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/quicksort_engine_core.sv =====
// Channel  Handshake           Payload                                 Direction
// in       in_valid/in_stall   value[31:0] signed, last                into block
// out      out_valid/out_stall sorted_value[31:0] signed, end_of_set,  out of block
//                              overflow
//
// Loading accepts one input transaction per cycle while the block is idle; the sort starts after the last one.
// Compares and swaps run on the shared comparator and store port; a swap passes through SW1, SW2
// and SW_WAIT, and each range adds stack and pivot work.
// Results leave at one per cycle from an output register that out_stall holds.
// in_stall is high while the block sorts or emits.
// Synchronous reset clears the state, item count, drop flag, stack pointer and out_valid.
module quicksort_engine_core
  import qse_pkg::*;
#(
  parameter int MAX_ITEMS = QSE_MAX_ITEMS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                      last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] sorted_value,
  output logic                      end_of_set,
  output logic                      overflow
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [3:0] {
    IDLE, POP, POP_WAIT, PV_FIRST, PV_SCAN, SP_L, SP_R,
    SW1, SW2, SW_WAIT, PUSH1, PUSH2, EMIT_PRE, EMIT
  } state_t;

  state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic dropped, dropped_next;
  logic [SP_W-1:0] sp, sp_next;
  logic [CW-1:0] ia, ia_next;
  logic [CW-1:0] rp, rp_next;
  logic [AW-1:0] lo, lo_next;
  logic [AW-1:0] hi, hi_next;
  logic signed [VALUE_W-1:0] first, first_next;
  logic signed [VALUE_W-1:0] pivot, pivot_next;
  logic signed [VALUE_W-1:0] tmp, tmp_next;
  logic out_valid_next;
  logic signed [VALUE_W-1:0] sorted_value_next;
  logic end_of_set_next;
  logic overflow_next;

  logic [AW-1:0] rd_addr_a, rd_addr_b, wr_addr;
  logic signed [VALUE_W-1:0] rd_data_a, rd_data_b, wr_data;
  logic wr_en;

  logic stk_wr_en;
  logic [STK_AW-1:0] stk_wr_addr, stk_rd_addr;
  stack_entry_t stk_wr_data, stk_rd_data;
  logic [SP_W-1:0] sp_m1;

  logic signed [VALUE_W-1:0] op_a, op_b;
  cmp_res_t cmp;

  logic accept, load;
  logic [CW-1:0] cnt_after, lo_c, hi_c, rp_m1_next;

  function automatic logic [AW-1:0] clamp_idx(input logic [CW-1:0] x);
    if (x < CW'(MAX_ITEMS)) begin
      return AW'(x);
    end
    return '0;
  endfunction

  qse_store #(.DEPTH(MAX_ITEMS)) u_store (
    .clk       (clk),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  qse_stack u_stack (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data)
  );

  qse_cmp u_cmp (
    .op_a (op_a),
    .op_b (op_b),
    .res  (cmp)
  );

  assign in_stall = (state != IDLE);
  assign accept = in_valid && !in_stall;
  assign load = !out_valid || !out_stall;
  assign op_a = (state == SP_R) ? rd_data_b : rd_data_a;
  assign op_b = (state == PV_SCAN) ? first : pivot;
  assign lo_c = CW'(lo);
  assign hi_c = CW'(hi);
  assign sp_m1 = sp - 1'b1;
  assign stk_rd_addr = sp_m1[STK_AW-1:0];
  assign cnt_after = (count < CW'(MAX_ITEMS)) ? CW'(count + 1'b1) : count;
  assign rp_m1_next = rp_next - 1'b1;
  assign rd_addr_a = clamp_idx(ia_next);
  assign rd_addr_b = clamp_idx(rp_m1_next);

  always_comb begin
    state_next = state;
    count_next = count;
    dropped_next = dropped;
    sp_next = sp;
    ia_next = ia;
    rp_next = rp;
    lo_next = lo;
    hi_next = hi;
    first_next = first;
    pivot_next = pivot;
    tmp_next = tmp;
    out_valid_next = out_valid && out_stall;
    sorted_value_next = sorted_value;
    end_of_set_next = end_of_set;
    overflow_next = overflow;
    wr_en = 1'b0;
    wr_addr = clamp_idx(ia);
    wr_data = rd_data_b;
    stk_wr_en = 1'b0;
    stk_wr_addr = sp[STK_AW-1:0];
    stk_wr_data = '0;

    unique case (state)
      IDLE: begin
        if (accept) begin
          if (count < CW'(MAX_ITEMS)) begin
            wr_en = 1'b1;
            wr_addr = AW'(count);
            wr_data = value;
            count_next = CW'(count + 1'b1);
          end else begin
            dropped_next = 1'b1;
          end
          if (last) begin
            if (cnt_after < CW'(2)) begin
              state_next = EMIT_PRE;
            end else begin
              stk_wr_en = 1'b1;
              stk_wr_addr = '0;
              stk_wr_data.lo = '0;
              stk_wr_data.hi = BOUND_W'(cnt_after - 1'b1);
              sp_next = SP_W'(1);
              state_next = POP;
            end
          end
        end
      end
      POP: begin
        if (sp == '0) begin
          state_next = EMIT_PRE;
        end else begin
          sp_next = sp_m1;
          state_next = POP_WAIT;
        end
      end
      POP_WAIT: begin
        if (stk_rd_data.lo >= stk_rd_data.hi ||
            (BOUND_W+1)'(stk_rd_data.hi) >= (BOUND_W+1)'(count)) begin
          state_next = POP;
        end else begin
          lo_next = AW'(stk_rd_data.lo);
          hi_next = AW'(stk_rd_data.hi);
          ia_next = CW'(stk_rd_data.lo);
          state_next = PV_FIRST;
        end
      end
      PV_FIRST: begin
        first_next = rd_data_a;
        ia_next = CW'(ia + 1'b1);
        state_next = PV_SCAN;
      end
      PV_SCAN: begin
        if (!cmp.eq) begin
          pivot_next = cmp.lt ? rd_data_a : first;
          ia_next = lo_c;
          rp_next = CW'(hi_c + 1'b1);
          state_next = SP_L;
        end else if (ia == hi_c) begin
          state_next = POP;
        end else begin
          ia_next = CW'(ia + 1'b1);
        end
      end
      SP_L: begin
        if (ia > hi_c) begin
          state_next = SP_R;
        end else if (cmp.lt || cmp.eq) begin
          ia_next = CW'(ia + 1'b1);
        end else begin
          state_next = SP_R;
        end
      end
      SP_R: begin
        if (rp > lo_c && !(cmp.lt || cmp.eq)) begin
          rp_next = rp - 1'b1;
        end else if ((CW+1)'(ia) + 1'b1 < (CW+1)'(rp)) begin
          state_next = SW1;
        end else if (ia < rp) begin
          state_next = SP_L;
        end else begin
          state_next = PUSH1;
        end
      end
      SW1: begin
        wr_en = 1'b1;
        wr_addr = clamp_idx(ia);
        wr_data = rd_data_b;
        tmp_next = rd_data_a;
        state_next = SW2;
      end
      SW2: begin
        wr_en = 1'b1;
        wr_addr = clamp_idx(rp - 1'b1);
        wr_data = tmp;
        ia_next = CW'(ia + 1'b1);
        rp_next = rp - 1'b1;
        state_next = SW_WAIT;
      end
      SW_WAIT: begin
        state_next = SP_L;
      end
      PUSH1: begin
        if (ia <= lo_c || ia > hi_c) begin
          state_next = POP;
        end else begin
          if (ia < hi_c && sp < SP_W'(STACK_DEPTH)) begin
            stk_wr_en = 1'b1;
            stk_wr_data.lo = BOUND_W'(ia);
            stk_wr_data.hi = BOUND_W'(hi);
            sp_next = sp + 1'b1;
          end
          state_next = PUSH2;
        end
      end
      PUSH2: begin
        if ((CW+1)'(ia) > (CW+1)'(lo_c) + 1'b1 && sp < SP_W'(STACK_DEPTH)) begin
          stk_wr_en = 1'b1;
          stk_wr_data.lo = BOUND_W'(lo);
          stk_wr_data.hi = BOUND_W'(ia - 1'b1);
          sp_next = sp + 1'b1;
        end
        state_next = POP;
      end
      EMIT_PRE: begin
        ia_next = '0;
        state_next = EMIT;
      end
      EMIT: begin
        if (load) begin
          out_valid_next = 1'b1;
          sorted_value_next = rd_data_a;
          overflow_next = dropped;
          if (CW'(ia + 1'b1) == count) begin
            end_of_set_next = 1'b1;
            count_next = '0;
            dropped_next = 1'b0;
            state_next = IDLE;
          end else begin
            end_of_set_next = 1'b0;
            ia_next = CW'(ia + 1'b1);
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      dropped <= 1'b0;
      sp <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      dropped <= dropped_next;
      sp <= sp_next;
      out_valid <= out_valid_next;
    end
    ia <= ia_next;
    rp <= rp_next;
    lo <= lo_next;
    hi <= hi_next;
    first <= first_next;
    pivot <= pivot_next;
    tmp <= tmp_next;
    sorted_value <= sorted_value_next;
    end_of_set <= end_of_set_next;
    overflow <= overflow_next;
  end

`ifndef SYNTHESIS
  a_swap_ordered: assert property (@(posedge clk) disable iff (rst)
    (state == SW1) |-> ((CW+1)'(ia) + 1'b1 < (CW+1)'(rp)))
    else $error("Swap entered without left index below right index.");

  a_left_bound: assert property (@(posedge clk) disable iff (rst)
    (state == SP_L) |-> ((CW+1)'(ia) <= (CW+1)'(hi_c) + 1'b1))
    else $error("Left scan index ran past the end of the range.");

  a_emit_index: assert property (@(posedge clk) disable iff (rst)
    (state == EMIT) |-> (ia < count))
    else $error("Emit index is outside the stored values.");

  a_range_proper: assert property (@(posedge clk) disable iff (rst)
    (state == PUSH1) |-> (lo < hi))
    else $error("Partition finished on a range with fewer than two entries.");
`endif

endmodule
